/* rtl/wlb_pkg.sv */
// Shared types and constants for the window/level to byte converter.
// Used by every module of the block and by its checker; depends on nothing.
package wlb_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 17;
    localparam int EXT_W      = THR_W + 1;
    localparam int QUO_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    // Divider shape: the span needs THR_W bits, the divisor is twice the span,
    // and the dividend 510 * num + span stays below 512 * span.
    localparam int SPAN_W = THR_W;
    localparam int DVS_W  = SPAN_W + 1;
    localparam int DEND_W = SPAN_W + QUO_W + 1;

    // Quotient bits resolved per divider stage.
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

    // Register stages from input to output port: two front stages,
    // the divider stages and the output register.
    localparam int PIPE_DEPTH = DIV_STAGES + 3;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [QUO_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [QUO_W-1:0] ZERO_BYTE  = 8'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIGNED  = 2'd2;

    // Current configuration as seen by the front end.
    typedef struct packed {
        logic signed [THR_W-1:0] low_threshold;
        logic signed [THR_W-1:0] high_threshold;
        logic                    sample_signed;
    } t_cfg;

    // One word in flight through the divider.
    typedef struct packed {
        logic              sat_zero;
        logic              sat_full;
        logic [DEND_W-1:0] rem;
        logic [DVS_W-1:0]  dvs;
        logic [QUO_W-1:0]  quo;
    } t_div_word;

endpackage

/* rtl/wlb_front.sv */
// Front end of the converter: classifies the sample against the window and
// builds the dividend and divisor for the rounding division. Uses wlb_pkg.
module wlb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wlb_pkg::t_cfg                   i_cfg,
    input  logic                            i_vld,
    output logic                            o_rdy,
    input  logic [wlb_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                            o_vld,
    input  logic                            i_rdy,
    output wlb_pkg::t_div_word              o_word
);

    // Stage A registers.
    logic                           r_a_vld;
    logic                           r_a_zero;
    logic                           r_a_full;
    logic [wlb_pkg::SPAN_W-1:0]     r_a_num;
    logic [wlb_pkg::SPAN_W-1:0]     r_a_span;

    // Stage B registers.
    logic                           r_b_vld;
    wlb_pkg::t_div_word             r_b_word;

    logic                           w_a_rdy;
    logic                           w_b_rdy;
    logic signed [wlb_pkg::EXT_W-1:0] w_v;
    logic signed [wlb_pkg::EXT_W-1:0] w_low;
    logic signed [wlb_pkg::EXT_W-1:0] w_high;
    logic signed [wlb_pkg::EXT_W-1:0] w_num;
    logic signed [wlb_pkg::EXT_W-1:0] w_span;
    logic                             w_le_low;
    logic                             w_ge_high;
    logic [wlb_pkg::DEND_W-1:0]       w_dend;

    // A stage takes a word when it is empty or its word moves on.
    assign w_b_rdy = !r_b_vld || i_rdy;
    assign w_a_rdy = !r_a_vld || w_b_rdy;
    assign o_rdy   = w_a_rdy;

    // Sample and thresholds extended to one common signed width.
    always_comb begin
        if (i_cfg.sample_signed) begin
            w_v = {{(wlb_pkg::EXT_W - wlb_pkg::SAMPLE_W){i_sample[wlb_pkg::SAMPLE_W-1]}},
                   i_sample};
        end else begin
            w_v = {{(wlb_pkg::EXT_W - wlb_pkg::SAMPLE_W){1'b0}}, i_sample};
        end
        w_low     = {i_cfg.low_threshold[wlb_pkg::THR_W-1], i_cfg.low_threshold};
        w_high    = {i_cfg.high_threshold[wlb_pkg::THR_W-1], i_cfg.high_threshold};
        w_le_low  = (w_v <= w_low);
        w_ge_high = (w_v >= w_high);
        w_num     = w_v - w_low;
        w_span    = w_high - w_low;
    end

    // Stage A: window tests. Inside the window 0 < num < span < 2^17.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_a_rdy) begin
            r_a_vld <= i_vld;
        end
        if (w_a_rdy && i_vld) begin
            r_a_zero <= w_le_low;
            r_a_full <= !w_le_low && w_ge_high;
            r_a_num  <= w_num[wlb_pkg::SPAN_W-1:0];
            r_a_span <= w_span[wlb_pkg::SPAN_W-1:0];
        end
    end

    // Dividend 510 * num + span, built from two shifts.
    assign w_dend = {r_a_num, {(wlb_pkg::QUO_W + 1){1'b0}}}
                  - {{wlb_pkg::QUO_W{1'b0}}, r_a_num, 1'b0}
                  + {{(wlb_pkg::QUO_W + 1){1'b0}}, r_a_span};

    // Stage B: dividend and divisor ready for the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_b_rdy) begin
            r_b_vld <= r_a_vld;
        end
        if (w_b_rdy && r_a_vld) begin
            r_b_word.sat_zero <= r_a_zero;
            r_b_word.sat_full <= r_a_full;
            r_b_word.rem      <= w_dend;
            r_b_word.dvs      <= {r_a_span, 1'b0};
            r_b_word.quo      <= wlb_pkg::ZERO_BYTE;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_word = r_b_word;

endmodule

/* rtl/wlb_divider.sv */
// Pipelined restoring divider: each stage resolves two quotient bits.
// Uses wlb_pkg for the word type and the stage count.
module wlb_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  wlb_pkg::t_div_word  i_word,
    output logic                o_vld,
    input  logic                i_rdy,
    output wlb_pkg::t_div_word  o_word
);

    logic               r_vld  [wlb_pkg::DIV_STAGES];
    wlb_pkg::t_div_word r_word [wlb_pkg::DIV_STAGES];
    logic               w_rdy  [wlb_pkg::DIV_STAGES + 1];
    logic               w_in_vld  [wlb_pkg::DIV_STAGES];
    wlb_pkg::t_div_word w_in_word [wlb_pkg::DIV_STAGES];
    wlb_pkg::t_div_word w_nxt     [wlb_pkg::DIV_STAGES];

    assign w_rdy[wlb_pkg::DIV_STAGES] = i_rdy;
    assign o_rdy = w_rdy[0];
    assign o_vld  = r_vld[wlb_pkg::DIV_STAGES-1];
    assign o_word = r_word[wlb_pkg::DIV_STAGES-1];

    for (genvar s = 0; s < wlb_pkg::DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_in_vld[s]  = i_vld;
            assign w_in_word[s] = i_word;
        end else begin : g_rest
            assign w_in_vld[s]  = r_vld[s-1];
            assign w_in_word[s] = r_word[s-1];
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        // Two trial subtractions of the shifted divisor, high bit first.
        always_comb begin
            logic [wlb_pkg::DEND_W-1:0] sh;
            int k;
            w_nxt[s] = w_in_word[s];
            for (int j = 0; j < wlb_pkg::STEPS_PER_STAGE; j++) begin
                k  = wlb_pkg::QUO_W - 1 - s * wlb_pkg::STEPS_PER_STAGE - j;
                sh = {{(wlb_pkg::DEND_W - wlb_pkg::DVS_W){1'b0}}, w_in_word[s].dvs} << k;
                if (w_nxt[s].rem >= sh) begin
                    w_nxt[s].rem    = w_nxt[s].rem - sh;
                    w_nxt[s].quo[k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_in_vld[s];
            end
            if (w_rdy[s] && w_in_vld[s]) begin
                r_word[s] <= w_nxt[s];
            end
        end
    end

endmodule

/* rtl/window_level_to_byte_top.sv */
// Top level of the window/level to byte converter: configuration registers,
// front end, divider and output register. Uses wlb_pkg, wlb_front, wlb_divider.
//
// Maps each 16-bit sample (unsigned, or two's complement when sample_signed is
// set) to a byte: 0 at or below low_threshold, 255 at or above high_threshold,
// and (v - low) * 255 / (high - low) rounded half up in between, exact to the
// bit. One word is accepted per clock while the output is not stalled. A word
// passes through seven register stages (two front stages, four divider stages
// of two quotient bits each, and the output register), and the results leave
// in order, one result per input. The pipeline is elastic: a stalled output
// holds every stage and empty stages fill up.
// Configuration registers are read directly by the front end and should be
// written only while no word is in flight.
module window_level_to_byte_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [wlb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wlb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_bits
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata    // [7:0] pixel_byte
);

    wlb_pkg::t_cfg      r_cfg;
    logic               r_out_vld;
    logic [7:0]         r_out_data;
    logic [7:0]         n_out_data;

    logic               w_front_vld;
    logic               w_front_rdy;
    wlb_pkg::t_div_word w_front_word;
    logic               w_div_vld;
    logic               w_div_rdy;
    wlb_pkg::t_div_word w_div_word;
    logic               w_out_rdy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold  <= '0;
            r_cfg.high_threshold <= '0;
            r_cfg.sample_signed  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wlb_pkg::CFG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data;
                wlb_pkg::CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data;
                wlb_pkg::CFG_SAMPLE_SIGNED:  r_cfg.sample_signed  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    wlb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_vld    (s_axis_tvalid),
        .o_rdy    (s_axis_tready),
        .i_sample (s_axis_tdata),
        .o_vld    (w_front_vld),
        .i_rdy    (w_front_rdy),
        .o_word   (w_front_word)
    );

    wlb_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .o_rdy   (w_front_rdy),
        .i_word  (w_front_word),
        .o_vld   (w_div_vld),
        .i_rdy   (w_div_rdy),
        .o_word  (w_div_word)
    );

    // Saturation overrides the quotient.
    always_comb begin
        priority if (w_div_word.sat_zero) begin
            n_out_data = wlb_pkg::ZERO_BYTE;
        end else if (w_div_word.sat_full) begin
            n_out_data = wlb_pkg::FULL_SCALE;
        end else begin
            n_out_data = w_div_word.quo;
        end
    end

    // Output register.
    assign w_out_rdy = !r_out_vld || m_axis_tready;
    assign w_div_rdy = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_vld <= w_div_vld;
        end
        if (w_out_rdy && w_div_vld) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

/* rtl/wlb_checker.sv */
// Port-level checker for the window/level to byte converter and its bind.
// Uses wlb_pkg for the pipeline depth; sees the top level's ports only.
module wlb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata
);

    logic [wlb_pkg::OCC_W-1:0] r_occ;
    logic                      w_in_acc;
    logic                      w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // Words accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + wlb_pkg::OCC_W'(w_in_acc) - wlb_pkg::OCC_W'(w_out_acc);
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // A result is shown only for a word that was taken in.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_occ != '0)
        else $error("result shown with no word in flight");

    // The pipeline never holds more words than it has stages.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= wlb_pkg::OCC_W'(wlb_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    // With the output register empty nothing blocks the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

endmodule

bind window_level_to_byte_top wlb_checker u_wlb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/wlb_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for window_level_to_byte_top: watches the register port and both
// streams, predicts each output byte and compares it. Depends on wlb_pkg.
module wlb_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wlb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wlb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [15:0]                    i_in_data,    // [15:0] sample_bits
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [7:0]                     i_out_data,   // [7:0] pixel_byte
    input  logic                           i_done,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    localparam int PRINT_CAP = 50;

    // Shadow copy of the window registers.
    logic signed [wlb_pkg::THR_W-1:0] win_low;
    logic signed [wlb_pkg::THR_W-1:0] win_high;
    logic                             read_signed;

    logic [wlb_pkg::QUO_W-1:0] expected_bytes[$];
    logic [wlb_pkg::QUO_W-1:0] want;
    int               fail_cnt    = 0;
    int               checked_cnt = 0;
    bit               leftovers_done = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Clamp the sample to the window and scale it, rounding half up.
    function automatic logic [wlb_pkg::QUO_W-1:0] stretch_to_byte(
        input logic [15:0]                      bits,
        input logic signed [wlb_pkg::THR_W-1:0] lo,
        input logic signed [wlb_pkg::THR_W-1:0] hi,
        input logic                             as_signed
    );
        longint v;
        longint span;
        longint num;
        longint q;
        if (as_signed) begin
            v = longint'($signed(bits));
        end else begin
            v = longint'(bits);
        end
        if (v <= longint'(lo)) return wlb_pkg::ZERO_BYTE;
        if (v >= longint'(hi)) return wlb_pkg::FULL_SCALE;
        span = longint'(hi) - longint'(lo);
        num  = v - longint'(lo);
        q    = (2 * num * longint'(wlb_pkg::FULL_SCALE) + span) / (2 * span);
        if (q > longint'(wlb_pkg::FULL_SCALE)) q = longint'(wlb_pkg::FULL_SCALE);
        return q[wlb_pkg::QUO_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_cnt < PRINT_CAP) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_low     = '0;
            win_high    = '0;
            read_signed = 1'b0;
            expected_bytes.delete();
        end else begin
            // Output side first, so a word taken at this edge cannot match
            // its own prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %0d with no sample in flight",
                                              i_out_data));
                end else begin
                    want = expected_bytes.pop_front();
                    checked_cnt++;
                    if (i_out_data !== want) begin
                        report_mismatch($sformatf("pixel_byte %0d, expected %0d",
                                                  i_out_data, want));
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                expected_bytes.push_back(stretch_to_byte(i_in_data, win_low,
                                                         win_high, read_signed));
            end

            // Register writes; an index past the list is ignored.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wlb_pkg::CFG_LOW_THRESHOLD:  win_low     = i_cfg_data;
                    wlb_pkg::CFG_HIGH_THRESHOLD: win_high    = i_cfg_data;
                    wlb_pkg::CFG_SAMPLE_SIGNED:  read_signed = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (expected_bytes.size() != 0) begin
                    report_mismatch($sformatf("%0d expected bytes never arrived",
                                              expected_bytes.size()));
                    expected_bytes.delete();
                end
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fail_cnt;
        o_checked    <= checked_cnt;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for window_level_to_byte_top: clock, reset, register writes,
// sample stimulus and the verdict. Depends on wlb_pkg and wlb_scoreboard.
module tb_top;

    localparam logic [wlb_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = wlb_pkg::PIPE_DEPTH + 5;
    localparam int NUM_SEGMENTS   = 14;
    localparam int SEG_SAMPLES    = 50;
    localparam int QUIET_SEGMENT  = 12;
    localparam int PAUSE_SEGMENT  = 5;
    localparam int THR_MIN        = -65536;
    localparam int THR_MAX        = 65535;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           cfg_we   = 1'b0;
    logic [wlb_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [wlb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid  = 1'b0;
    logic                           s_ready;
    logic [15:0]                    s_data   = '0;
    logic                           m_valid;
    logic                           m_ready  = 1'b0;
    logic [7:0]                     m_data;
    logic                           done     = 1'b0;

    int fail_count;
    int pending;
    int checked;

    bit gaps_on     = 1'b1;
    bit stream_open = 1'b0;
    int stall_left  = 0;
    int cycle_cnt   = 0;
    int sent_cnt    = 0;
    int window_cnt  = 0;

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    window_level_to_byte_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    wlb_scoreboard u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_done       (done),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Receiver: random stall bursts while gaps are enabled.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                     cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [wlb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wlb_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic stop_sending();
        if (stream_open) begin
            s_valid    <= 1'b0;
            stream_open = 1'b0;
            @(posedge clk);
        end
    endtask

    // Wait for every expected byte, then let the pipeline settle.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input int lo, input int hi, input bit as_signed);
        stop_sending();
        wait_drained();
        write_reg(wlb_pkg::CFG_LOW_THRESHOLD, wlb_pkg::CFG_DATA_W'(lo));
        write_reg(wlb_pkg::CFG_HIGH_THRESHOLD, wlb_pkg::CFG_DATA_W'(hi));
        write_reg(wlb_pkg::CFG_SAMPLE_SIGNED, wlb_pkg::CFG_DATA_W'(as_signed));
        window_cnt++;
    endtask

    // Send one word, with an occasional idle burst ahead of it.
    task automatic send_sample(input logic [15:0] bits);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            if (stream_open) s_valid <= 1'b0;
            stream_open = 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid    <= 1'b1;
        s_data     <= bits;
        stream_open = 1'b1;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sent_cnt++;
    endtask

    // Samples cluster around both thresholds and inside the window.
    function automatic logic [15:0] pick_sample(input int lo, input int hi,
                                                input bit as_signed);
        int vmin;
        int vmax;
        int a;
        int b;
        int v;
        vmin = as_signed ? -32768 : 0;
        vmax = as_signed ? 32767 : 65535;
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: v = lo + int'($urandom_range(0, 4)) - 2;
            2: v = hi + int'($urandom_range(0, 4)) - 2;
            default: begin
                a = (lo > vmin) ? lo : vmin;
                b = (hi < vmax) ? hi : vmax;
                if (a >= b) return 16'($urandom);
                v = a + int'($urandom_range(0, b - a));
            end
        endcase
        if (v < vmin) v = vmin;
        if (v > vmax) v = vmax;
        return v[15:0];
    endfunction

    function automatic int pick_threshold(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Choose the window for one random segment.
    task automatic random_window(input int seg, output int lo, output int hi,
                                 output bit as_signed);
        int vmin;
        int vmax;
        int t;
        as_signed = 1'($urandom_range(0, 1));
        vmin = as_signed ? -32768 : 0;
        vmax = as_signed ? 32767 : 65535;
        case (seg)
            0: begin lo = THR_MIN; hi = THR_MAX; end
            1: begin lo = THR_MAX; hi = THR_MIN; end
            2: begin lo = pick_threshold(vmin, vmax); hi = lo; end
            default: begin
                case ($urandom_range(0, 9))
                    0: begin
                        lo = pick_threshold(vmin, vmax);
                        hi = lo;
                    end
                    1: begin
                        lo = pick_threshold(vmin, vmax);
                        hi = pick_threshold(vmin, vmax);
                        if (lo < hi) begin t = lo; lo = hi; hi = t; end
                    end
                    2: begin
                        lo = pick_threshold(THR_MIN, THR_MAX);
                        hi = pick_threshold(THR_MIN, THR_MAX);
                    end
                    3: begin
                        lo = pick_threshold(vmin, vmax - 4);
                        hi = lo + int'($urandom_range(1, 4));
                    end
                    default: begin
                        lo = pick_threshold(vmin, vmax);
                        hi = pick_threshold(vmin, vmax);
                        if (lo > hi) begin t = lo; lo = hi; hi = t; end
                    end
                endcase
            end
        endcase
    endtask

    initial begin
        int lo;
        int hi;
        bit as_signed;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: both thresholds zero, unsigned reads.
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        // Ordinary window, both edges and the interior.
        set_window(100, 1100, 1'b0);
        send_sample(16'd100);
        send_sample(16'd101);
        send_sample(16'd600);
        send_sample(16'd1099);
        send_sample(16'd1100);
        send_sample(16'hFFFF);

        // Exact half step, which rounds up.
        set_window(0, 2, 1'b0);
        send_sample(16'd1);

        // Two's complement reads across the full signed range.
        set_window(-32768, 32767, 1'b1);
        send_sample(16'h8000);
        send_sample(16'h8001);
        send_sample(16'h7FFF);
        send_sample(16'h7FFE);
        send_sample(16'h0000);
        send_sample(16'hFFFF);

        // Inverted window: low above high.
        set_window(500, -500, 1'b1);
        send_sample(16'h0000);
        send_sample(16'd500);
        send_sample(16'd501);

        // Zero-width window.
        set_window(1000, 1000, 1'b0);
        send_sample(16'd1000);
        send_sample(16'd1001);

        // Thresholds beyond the sample range, plus a write to the spare index.
        set_window(THR_MIN, THR_MAX, 1'b0);
        write_reg(CFG_SPARE_IDX, wlb_pkg::CFG_DATA_W'($urandom));
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);

        // Random segments, each under its own window.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            random_window(seg, lo, hi, as_signed);
            set_window(lo, hi, as_signed);
            if (seg >= QUIET_SEGMENT) gaps_on = 1'b0;
            for (int n = 0; n < SEG_SAMPLES; n++) begin
                if (seg == PAUSE_SEGMENT && n == SEG_SAMPLES / 2) begin
                    // Hold the sender until the pipeline has emptied.
                    stop_sending();
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                send_sample(pick_sample(lo, hi, as_signed));
            end
        end

        stop_sending();
        wait_drained();
        done <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Sent %0d samples under %0d window settings; %0d bytes compared.",
                 sent_cnt, window_cnt, checked);
        $display("Covered unsigned and signed reads, inverted and zero-width windows, "
                 , "and thresholds past the sample range.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
